>>> src/acmac_pkg.sv
// ============================================================================
// acmac_pkg: shared types and functions for the AES-128-CMAC engine
// Holds the S-box, the round helpers and the command word that passes
// from the front part to the back part.
// ============================================================================
package acmac_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
    localparam logic [1:0] REG_KEY_LOW   = 2'd1;
    localparam logic [1:0] REG_SHORT_TAG = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    // classified block handed to the back part
    typedef struct packed {
        logic [127:0] msg;     // masked and padded block (subkey not yet applied)
        logic         last;
        logic         full;    // last block used all 16 bytes
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUBKEY,
        ST_BLOCK
    } t_state;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a 128-bit word, byte 0 most significant
    function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
        return w[127 - 8*i -: 8];
    endfunction

    // one round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         final_rnd);
        logic [7:0]   t [16];
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3, e;
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                t[j + 4*c] = sbox(byte_at(s, j + 4*((c + j) & 3)));
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            e  = a0 ^ a1 ^ a2 ^ a3;
            if (final_rnd) begin
                o[127 - 32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[127 - 32*c -: 32] = {a0 ^ e ^ xtime(a0 ^ a1), a1 ^ e ^ xtime(a1 ^ a2),
                                       a2 ^ e ^ xtime(a2 ^ a3), a3 ^ e ^ xtime(a3 ^ a0)};
            end
        end
        return o ^ rk;
    endfunction

    // next round key from the previous one
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0]  w;
        logic [127:0] o;
        w = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
        o[127:96] = k[127:96] ^ w;
        o[95:64]  = k[95:64]  ^ o[127:96];
        o[63:32]  = k[63:32]  ^ o[95:64];
        o[31:0]   = k[31:0]   ^ o[63:32];
        return o;
    endfunction

    function automatic logic [7:0] next_rcon(input logic [7:0] rc);
        return xtime(rc);
    endfunction

    // doubling in GF(2^128)
    function automatic logic [127:0] gf_dbl(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
    endfunction

endpackage

>>> src/acmac_stream_if.sv
// ============================================================================
// acmac_stream_if: valid/ready channel with a generic payload
// Used for both the block input and the tag output.
// ============================================================================
interface acmac_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/acmac_front.sv
// ============================================================================
// acmac_front: block intake and command queue
// Masks and pads the last block and queues classified blocks for the core.
// ============================================================================
module acmac_front
    import acmac_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input block transfer
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [63:0]  i_block_high,
    input  logic [63:0]  i_block_low,
    input  logic [4:0]   i_byte_count,
    input  logic         i_last_block,
    // command toward the core
    output logic         o_cmd_valid,
    input  logic         i_cmd_ready,
    output t_cmd         o_cmd
);

    t_cmd        r_q [QUEUE_DEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_cmd        n_cmd;
    logic        push, pop;
    logic [127:0] blk, mask, pad;
    logic [4:0]  n_sat;

    // classify: full blocks pass, a partial last block gets 10* padding
    always_comb begin
        blk   = {i_block_high, i_block_low};
        n_sat = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
        mask  = '0;
        pad   = '0;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < n_sat) mask[127 - 8*i -: 8] = 8'hff;
            if (5'(i) == n_sat) pad[127 - 8*i -: 8] = 8'h80;
        end
        n_cmd.last = i_last_block;
        n_cmd.full = (n_sat == 5'd16);
        n_cmd.msg  = (i_last_block && n_sat != 5'd16) ? ((blk & mask) | pad) : blk;
    end

    assign o_ready     = (r_cnt != 2'(QUEUE_DEPTH));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_cmd;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(QUEUE_DEPTH) |-> !push) else $error("push into full queue");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count mismatch");

endmodule

>>> src/acmac_core.sv
// ============================================================================
// acmac_core: iterative AES-128 round unit with CMAC chaining
// One round per cycle; derives L on first use after a key change.
// ============================================================================
module acmac_core
    import acmac_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [127:0] i_key,
    input  logic         i_key_wr,
    input  logic         i_short_tag,
    input  logic         i_cmd_valid,
    output logic         o_cmd_ready,
    input  t_cmd         i_cmd,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [127:0] o_mac
);

    t_state       r_state, n_state;
    logic [127:0] r_st, r_rk, r_chain, r_l, r_mac;
    logic [7:0]   r_rc;
    logic [3:0]   r_rnd;
    logic         r_ready_l, r_last, r_out_v;
    logic [127:0] k1, k2, din, rnd_out, chain_src;
    logic         load, start_blk, done, out_busy;

    assign k1 = gf_dbl(r_l);
    assign k2 = gf_dbl(k1);
    assign rnd_out = aes_round(r_st, key_step(r_rk, r_rc), r_rnd == 4'd10);
    assign done = (r_rnd == 4'd10);

    // a block loaded on the final round chains from the value just computed
    assign chain_src = (r_state == ST_BLOCK && done) ? (r_last ? 128'h0 : rnd_out)
                                                     : r_chain;
    assign din = chain_src ^ i_cmd.msg
               ^ (i_cmd.last ? (i_cmd.full ? k1 : k2) : 128'h0);

    // the output register must be free before a tag-producing block finishes
    assign out_busy   = (r_out_v && !i_ready) || (r_state == ST_BLOCK && done && r_last);
    assign start_blk  = i_cmd_valid && r_ready_l && !(i_cmd.last && out_busy);
    assign o_cmd_ready = (r_state == ST_IDLE || (r_state == ST_BLOCK && done))
                         && start_blk && !i_key_wr;
    assign load = o_cmd_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !r_ready_l && !i_key_wr) n_state = ST_SUBKEY;
                else if (load) n_state = ST_BLOCK;
            end
            ST_SUBKEY: begin
                if (done) n_state = ST_IDLE;
            end
            ST_BLOCK: begin
                if (done) n_state = load ? ST_BLOCK : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_l <= 1'b0;
            r_chain   <= '0;
            r_out_v   <= 1'b0;
            r_rnd     <= 4'd0;
            r_last    <= 1'b0;
        end else begin
            if (o_valid && i_ready) r_out_v <= 1'b0;
            if (r_state != ST_IDLE && !done) begin
                r_st  <= rnd_out;
                r_rk  <= key_step(r_rk, r_rc);
                r_rc  <= next_rcon(r_rc);
                r_rnd <= r_rnd + 4'd1;
            end
            if (r_state == ST_SUBKEY && done) begin
                r_l       <= rnd_out;
                r_ready_l <= 1'b1;
            end
            if (r_state == ST_BLOCK && done) begin
                if (r_last) begin
                    r_mac   <= {rnd_out[127:64], i_short_tag ? 64'h0 : rnd_out[63:0]};
                    r_out_v <= 1'b1;
                    r_chain <= '0;
                end else begin
                    r_chain <= rnd_out;
                end
            end
            if (r_state == ST_IDLE && i_cmd_valid && !r_ready_l && !i_key_wr) begin
                r_st  <= i_key;
                r_rk  <= i_key;
                r_rc  <= 8'h01;
                r_rnd <= 4'd1;
            end
            if (load) begin
                r_st   <= din ^ i_key;
                r_rk   <= i_key;
                r_rc   <= 8'h01;
                r_rnd  <= 4'd1;
                r_last <= i_cmd.last;
            end
            if (r_state != ST_IDLE && done && !load) r_rnd <= 4'd0;
            if (i_key_wr) r_ready_l <= 1'b0;
        end
    end

    assign o_valid = r_out_v;
    assign o_mac   = r_mac;

    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd <= 4'd10) else $error("round count out of range");
    a_tag_chain_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> r_chain == 128'h0) else $error("chain not cleared");
    a_load_needs_l: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> r_ready_l) else $error("block started without subkeys");

endmodule

>>> src/aes128_cmac_engine.sv
// ============================================================================
// aes128_cmac_engine: AES-128-CMAC over 16-byte blocks
//   channel   dir  payload
//   s_in      in   block_high, block_low, byte_count, last_block
//   m_out     out  mac_high, mac_low
//   cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data
// One AES round per cycle in the round unit; L = AES(K,0) is also derived
// there before the first block after a key write.
// Synchronous active-low reset clears the chain and the subkey flag.
// A two-entry queue lets blocks arrive while the round unit is busy; a tag
// waiting in the output register stalls only the next last block.
// ============================================================================
module aes128_cmac_engine
    import acmac_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    acmac_stream_if.sink   s_in,
    acmac_stream_if.source m_out,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);

    logic [63:0] r_key_high, r_key_low;
    logic        r_short_tag;
    logic        cmd_valid, cmd_ready, key_wr;
    t_cmd        cmd;

    assign key_wr = i_cfg_we && (i_cfg_idx == REG_KEY_HIGH || i_cfg_idx == REG_KEY_LOW);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high  <= '0;
            r_key_low   <= '0;
            r_short_tag <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY_HIGH:  r_key_high  <= i_cfg_data;
                REG_KEY_LOW:   r_key_low   <= i_cfg_data;
                REG_SHORT_TAG: r_short_tag <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    acmac_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_block_high(s_in.data[133:70]), .i_block_low(s_in.data[69:6]),
        .i_byte_count(s_in.data[5:1]), .i_last_block(s_in.data[0]),
        .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    acmac_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_key({r_key_high, r_key_low}), .i_key_wr(key_wr),
        .i_short_tag(r_short_tag),
        .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready), .i_cmd(cmd),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_mac(m_out.data)
    );

endmodule

>>> bench/aes128_cmac_engine_test.sv
`timescale 1ns / 1ps
// ============================================================================
// aes128_cmac_engine_test: self-checking bench for the AES-128-CMAC engine
// Feeds messages as 16-byte blocks through the input channel. A local CMAC
// calculator predicts every tag, and tags are checked in order as they leave
// the output channel. Directed rows use the published AES-CMAC vectors, and a
// random phase follows with key and tag-mode changes and both sides stalling.
// ============================================================================
module aes128_cmac_engine_test
    import acmac_pkg::*;
;

    localparam logic [1:0] REG_UNUSED = 2'd3;   // index past the register list
    localparam int         LIMIT      = 400000;
    localparam int         SETTLE     = 80;     // two queued blocks plus subkey work

    typedef enum logic [1:0] { ROW_BLOCK, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind    kind;
        logic [1:0]   idx;       // register index for config rows
        logic [63:0]  hi;        // block_high, or config data
        logic [63:0]  lo;
        logic [4:0]   cnt;
        logic         last;
        logic         has_tag;   // tag typed in below
        logic [127:0] tag;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    acmac_stream_if #(.W(134)) in_ch ();
    acmac_stream_if #(.W(128)) out_ch ();

    aes128_cmac_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0] sbox_tab [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    // CMAC calculator state
    logic [127:0] cm_key;
    logic         cm_short;
    logic [127:0] cm_chain;
    logic [127:0] cm_l;
    logic         cm_l_ok;

    logic [127:0] tags_due [$];
    int           fails = 0;
    int           blocks_sent;
    int           tags_seen = 0;
    int           cycles = 0;
    int           burst_left;

    function automatic logic [7:0] mul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // AES-128 encryption, byte 0 in the top bits
    function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                 input logic [127:0] pt);
        logic [127:0] rk, s, t;
        logic [7:0]   rc, a0, a1, a2, a3, e;
        logic [31:0]  w;
        rk = key;
        s  = pt ^ rk;
        rc = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    t[127 - 8*(j + 4*c) -: 8] = sbox_tab[s[127 - 8*(j + 4*((c + j) % 4)) -: 8]];
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[127 - 32*c -: 8];
                    a1 = t[119 - 32*c -: 8];
                    a2 = t[111 - 32*c -: 8];
                    a3 = t[103 - 32*c -: 8];
                    e  = a0 ^ a1 ^ a2 ^ a3;
                    s[127 - 32*c -: 32] = {a0 ^ e ^ mul2(a0 ^ a1), a1 ^ e ^ mul2(a1 ^ a2),
                                           a2 ^ e ^ mul2(a2 ^ a3), a3 ^ e ^ mul2(a3 ^ a0)};
                end
            end else begin
                s = t;
            end
            w = {sbox_tab[rk[23:16]] ^ rc, sbox_tab[rk[15:8]], sbox_tab[rk[7:0]],
                 sbox_tab[rk[31:24]]};
            rk[127:96] = rk[127:96] ^ w;
            rk[95:64]  = rk[95:64]  ^ rk[127:96];
            rk[63:32]  = rk[63:32]  ^ rk[95:64];
            rk[31:0]   = rk[31:0]   ^ rk[63:32];
            rc = mul2(rc);
            s = s ^ rk;
        end
        return s;
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
    endfunction

    // absorb one block; returns 1 with the tag when the block ends a message
    function automatic bit cmac_absorb(input logic [63:0] hi, input logic [63:0] lo,
                                       input logic [4:0] cnt, input logic last,
                                       output logic [127:0] tag);
        logic [127:0] m, k1, k2, mask;
        int           n;
        m = {hi, lo};
        tag = '0;
        if (!cm_l_ok) begin
            cm_l = aes_encrypt(cm_key, 128'h0);
            cm_l_ok = 1'b1;
        end
        if (!last) begin
            cm_chain = aes_encrypt(cm_key, cm_chain ^ m);
            return 1'b0;
        end
        k1 = gf_double(cm_l);
        k2 = gf_double(k1);
        n  = (cnt >= 16) ? 16 : int'(cnt);
        if (n == 16) begin
            m = m ^ k1;
        end else begin
            mask = (n == 0) ? 128'h0 : ~(128'h0) << (8*(16 - n));
            m = ((m & mask) | (128'h80 << (8*(15 - n)))) ^ k2;
        end
        tag = aes_encrypt(cm_key, cm_chain ^ m);
        if (cm_short) tag[63:0] = '0;
        cm_chain = '0;
        return 1'b1;
    endfunction

    // hold the sender and let every queued block drain before a register write
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (tags_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_KEY_HIGH: begin
                cm_key[127:64] = data;
                cm_l_ok = 1'b0;
            end
            REG_KEY_LOW: begin
                cm_key[63:0] = data;
                cm_l_ok = 1'b0;
            end
            REG_SHORT_TAG: cm_short = data[0];
            default: ;
        endcase
    endtask

    // one block transfer; a typed tag, when given, replaces the predicted one
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [4:0] cnt, input logic last,
                              input logic has_tag, input logic [127:0] typed);
        logic [127:0] tag;
        int           gap;
        in_ch.data  <= {hi, lo, cnt, last};
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        blocks_sent++;
        if (cmac_absorb(hi, lo, cnt, last, tag)) tags_due.push_back(has_tag ? typed : tag);
        // bursts of random length, random gaps between them
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // tag receiver: stall pattern switches between steady, random and sparse
    int rx_mode = 0;
    int rx_tick = 0;
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 97 == 0) rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 1);
            default: out_ch.ready <= (rx_tick % 5 == 0);
        endcase
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            tags_seen <= tags_seen + 1;
            if (tags_due.size() == 0) begin
                $display("%0t: unexpected tag %h", $time, out_ch.data);
                fails++;
            end else begin
                if (out_ch.data[127:64] !== tags_due[0][127:64]) begin
                    $display("%0t: mac_high expected %h actual %h", $time,
                             tags_due[0][127:64], out_ch.data[127:64]);
                    fails++;
                end
                if (out_ch.data[63:0] !== tags_due[0][63:0]) begin
                    $display("%0t: mac_low expected %h actual %h", $time,
                             tags_due[0][63:0], out_ch.data[63:0]);
                    fails++;
                end
                void'(tags_due.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t: timeout with %0d tags pending", $time, tags_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // directed rows: published vectors, short tags, count extremes, key changes
    t_row rows [] = '{
        '{ROW_CFG, REG_KEY_HIGH, 64'h2b7e151628aed2a6, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_KEY_LOW, 64'habf7158809cf4f3c, 0, 0, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'h0, 64'h0, 5'd0, 1, 1,
          128'hbb1d6929e95937287fa37d129b756746},
        '{ROW_BLOCK, 0, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1, 1,
          128'h070a16b46b4d4144f79bdd9dd04a287c},
        '{ROW_BLOCK, 0, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd16, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'h30c81c46a35ce411, 64'he5fbc1191a0a52ef, 5'd8, 1, 1,
          128'hdfa66747de9ae63030ca32611497c827},
        '{ROW_CFG, REG_SHORT_TAG, 64'h1, 0, 0, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd0, 1, 1,
          128'hbb1d6929e95937280000000000000000},
        '{ROW_BLOCK, 0, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd31, 1, 0, 0},
        '{ROW_CFG, REG_SHORT_TAG, 64'hfffffffffffffffe, 0, 0, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'hffffffffffffffff, 64'hffffffffffffffff, 5'd17, 1, 0, 0},
        '{ROW_BLOCK, 0, 64'hffffffffffffffff, 64'h0, 5'd1, 1, 0, 0},
        '{ROW_BLOCK, 0, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1, 0, 0},
        '{ROW_BLOCK, 0, 64'hdeadbeef00c0ffee, 64'h55aa55aa55aa55aa, 5'd3, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'h0, 64'h0, 5'd7, 1, 0, 0},
        '{ROW_CFG, REG_UNUSED, 64'hffffffffffffffff, 0, 0, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'h1111111111111111, 64'h2222222222222222, 5'd16, 0, 0, 0},
        '{ROW_CFG, REG_KEY_HIGH, 64'hffffffffffffffff, 0, 0, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'h3333333333333333, 64'h4444444444444444, 5'd9, 1, 0, 0},
        '{ROW_CFG, REG_KEY_LOW, 64'hffffffffffffffff, 0, 0, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'h8000000000000000, 64'h1, 5'd16, 1, 0, 0},
        '{ROW_CFG, REG_KEY_HIGH, 64'h0, 0, 0, 0, 0, 0},
        '{ROW_CFG, REG_KEY_LOW, 64'h0, 0, 0, 0, 0, 0},
        '{ROW_BLOCK, 0, 64'h0, 64'h0, 5'd16, 1, 0, 0}
    };

    initial begin
        int n_blocks;
        int cnt;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        blocks_sent = 0;
        burst_left = 1;
        cm_key = '0;
        cm_short = 1'b0;
        cm_chain = '0;
        cm_l = '0;
        cm_l_ok = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG)
                cfg_write(rows[i].idx, rows[i].hi);
            else
                send_block(rows[i].hi, rows[i].lo, rows[i].cnt, rows[i].last,
                           rows[i].has_tag, rows[i].tag);
        end

        // random messages with random content; registers change now and then
        while (blocks_sent < 450) begin
            if ($urandom_range(0, 9) == 0) begin
                cfg_write(REG_KEY_HIGH, {$urandom, $urandom});
                cfg_write(REG_KEY_LOW, {$urandom, $urandom});
            end
            if ($urandom_range(0, 7) == 0) cfg_write(REG_SHORT_TAG, {$urandom, $urandom});
            if ($urandom_range(0, 40) == 0) cfg_write(REG_UNUSED, {$urandom, $urandom});
            n_blocks = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            for (int b = 0; b < n_blocks; b++) begin
                if (b == n_blocks - 1) begin
                    case ($urandom_range(0, 3))
                        0: cnt = 16;
                        1: cnt = 0;
                        2: cnt = $urandom_range(17, 31);
                        default: cnt = $urandom_range(1, 15);
                    endcase
                end else begin
                    cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : 16;
                end
                // key change in the middle of a message
                if (b > 0 && $urandom_range(0, 30) == 0)
                    cfg_write(REG_KEY_LOW, {$urandom, $urandom});
                send_block({$urandom, $urandom}, {$urandom, $urandom}, cnt[4:0],
                           b == n_blocks - 1, 1'b0, '0);
            end
        end

        in_ch.valid <= 1'b0;
        while (tags_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d blocks and checked %0d tags across key, tag-mode and length changes.",
                 blocks_sent, tags_seen);
        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", fails);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
src/acmac_pkg.sv
src/acmac_stream_if.sv
src/acmac_front.sv
src/acmac_core.sv
src/aes128_cmac_engine.sv
bench/aes128_cmac_engine_test.sv
